/* hdl/dpd_pkg.sv */
// ----------------------------------------------------------------------------
// dpd_pkg: shared types and constants for the depth pixel deprojection block
// Field widths, register map, pipeline link payloads and the fixed third
// radial coefficient.
// ----------------------------------------------------------------------------
package dpd_pkg;

    // field widths
    localparam int PIX_W    = 12;
    localparam int DEPTH_W  = 16;
    localparam int COORD_W  = 19;
    localparam int FOCAL_W  = 24;
    localparam int CENTER_W = 16;
    localparam int COEF_W   = 24;

    // fixed point
    localparam int FRAC     = 20;
    localparam int NORM_W   = 23;
    localparam int FACTOR_W = 42;
    localparam int TAN_W    = 54;
    localparam int UNIT_W   = 43;

    // configuration port
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // third radial coefficient, signed Q4.20
    localparam logic signed [COEF_W-1:0] DIST_K3 = 24'sd0;

    // register map, word index
    typedef enum logic [2:0] {
        REG_INV_FOCAL_X = 3'd0,
        REG_INV_FOCAL_Y = 3'd1,
        REG_CENTER_X    = 3'd2,
        REG_CENTER_Y    = 3'd3,
        REG_RADIAL_K1   = 3'd4,
        REG_RADIAL_K2   = 3'd5,
        REG_TANGENT_P1  = 3'd6,
        REG_TANGENT_P2  = 3'd7
    } reg_idx_t;

    // camera model registers
    typedef struct packed {
        logic        [FOCAL_W-1:0]  inv_focal_x;
        logic        [FOCAL_W-1:0]  inv_focal_y;
        logic        [CENTER_W-1:0] center_x;
        logic        [CENTER_W-1:0] center_y;
        logic signed [COEF_W-1:0]   radial_k1;
        logic signed [COEF_W-1:0]   radial_k2;
        logic signed [COEF_W-1:0]   tangential_p1;
        logic signed [COEF_W-1:0]   tangential_p2;
    } cfg_t;

    // normalised coordinates, Q2.20
    typedef struct packed {
        logic signed [NORM_W-1:0] xn;
        logic signed [NORM_W-1:0] yn;
        logic        [DEPTH_W-1:0] depth;
    } norm_t;

    // undistorted ray direction, Q.20
    typedef struct packed {
        logic signed [UNIT_W-1:0] ux;
        logic signed [UNIT_W-1:0] uy;
        logic        [DEPTH_W-1:0] depth;
    } ray_t;

endpackage

/* hdl/dpd_pixel_if.sv */
// ----------------------------------------------------------------------------
// dpd_pixel_if: pixel input channel
// One beat carries a pixel column, row and its depth.
// ----------------------------------------------------------------------------
interface dpd_pixel_if import dpd_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   pixel_col;
    logic [PIX_W-1:0]   pixel_row;
    logic [DEPTH_W-1:0] depth_mm;

    modport source (output valid, output pixel_col, output pixel_row, output depth_mm,
                    input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, input depth_mm,
                    output ready);

endinterface

/* hdl/dpd_point_if.sv */
// ----------------------------------------------------------------------------
// dpd_point_if: point output channel
// One beat carries a camera-frame point in millimetres and a clip flag.
// ----------------------------------------------------------------------------
interface dpd_point_if import dpd_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic        [DEPTH_W-1:0] point_z;
    logic                      saturated;

    modport source (output valid, output point_x, output point_y, output point_z,
                    output saturated, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    input saturated, output ready);

endinterface

/* hdl/dpd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dpd_cfg_regs: camera model register file
// APB-style write and read of the eight intrinsic and distortion registers.
// ----------------------------------------------------------------------------
module dpd_cfg_regs import dpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t wr_idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_idx)
                REG_INV_FOCAL_X: cfg_next.inv_focal_x   = pwdata[FOCAL_W-1:0];
                REG_INV_FOCAL_Y: cfg_next.inv_focal_y   = pwdata[FOCAL_W-1:0];
                REG_CENTER_X:    cfg_next.center_x      = pwdata[CENTER_W-1:0];
                REG_CENTER_Y:    cfg_next.center_y      = pwdata[CENTER_W-1:0];
                REG_RADIAL_K1:   cfg_next.radial_k1     = $signed(pwdata[COEF_W-1:0]);
                REG_RADIAL_K2:   cfg_next.radial_k2     = $signed(pwdata[COEF_W-1:0]);
                REG_TANGENT_P1:  cfg_next.tangential_p1 = $signed(pwdata[COEF_W-1:0]);
                REG_TANGENT_P2:  cfg_next.tangential_p2 = $signed(pwdata[COEF_W-1:0]);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage, defaults for a 640x480 view
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_focal_x   <= 24'd27962;
            cfg_reg.inv_focal_y   <= 24'd27962;
            cfg_reg.center_x      <= 16'd5120;
            cfg_reg.center_y      <= 16'd3840;
            cfg_reg.radial_k1     <= '0;
            cfg_reg.radial_k2     <= '0;
            cfg_reg.tangential_p1 <= '0;
            cfg_reg.tangential_p2 <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux, coefficients sign extended
    always_comb
    begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
            REG_INV_FOCAL_X: prdata = DATA_W'(cfg_reg.inv_focal_x);
            REG_INV_FOCAL_Y: prdata = DATA_W'(cfg_reg.inv_focal_y);
            REG_CENTER_X:    prdata = DATA_W'(cfg_reg.center_x);
            REG_CENTER_Y:    prdata = DATA_W'(cfg_reg.center_y);
            REG_RADIAL_K1:   prdata = DATA_W'(cfg_reg.radial_k1);
            REG_RADIAL_K2:   prdata = DATA_W'(cfg_reg.radial_k2);
            REG_TANGENT_P1:  prdata = DATA_W'(cfg_reg.tangential_p1);
            REG_TANGENT_P2:  prdata = DATA_W'(cfg_reg.tangential_p2);
            default:         prdata = '0;
        endcase
    end

    // an X principal point write lands in the register in the next cycle
    a_center_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && wr_idx == REG_CENTER_X) |=> cfg_reg.center_x == $past(pwdata[CENTER_W-1:0]))
        else $error("center_x write lost");

endmodule

/* hdl/dpd_norm.sv */
// ----------------------------------------------------------------------------
// dpd_norm: pixel to normalised image coordinates
// Two stages: principal point offset, then reciprocal focal scaling with
// rounding and clamping to Q2.20.
// ----------------------------------------------------------------------------
module dpd_norm import dpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PIX_W-1:0]   pixel_col,
    input  logic [PIX_W-1:0]   pixel_row,
    input  logic [DEPTH_W-1:0] depth_mm,
    output logic               out_valid,
    input  logic               out_ready,
    output norm_t              out_data
);

    localparam int DIFF_W = CENTER_W + 2;
    localparam int PROD_W = DIFF_W + FOCAL_W + 1;
    localparam int SCALE_SH = 8;
    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) <<< (SCALE_SH - 1);
    localparam logic signed [PROD_W-1:0] NORM_HI  = (PROD_W'(1) <<< (NORM_W - 1)) - 1;
    localparam logic signed [PROD_W-1:0] NORM_LO  = -(PROD_W'(1) <<< (NORM_W - 1));

    function automatic logic signed [NORM_W-1:0] clamp_norm(input logic signed [PROD_W-1:0] v);
        if (v > NORM_HI)
            clamp_norm = NORM_HI[NORM_W-1:0];
        else if (v < NORM_LO)
            clamp_norm = NORM_LO[NORM_W-1:0];
        else
            clamp_norm = v[NORM_W-1:0];
    endfunction

    logic                      v1_reg, v2_reg;
    logic                      en1, en2;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic signed [DIFF_W-1:0]  dx_next, dy_next;
    logic        [DEPTH_W-1:0] d1_reg, d2_reg;
    logic signed [PROD_W-1:0]  px_prod, py_prod, px_rnd, py_rnd;
    logic signed [NORM_W-1:0]  xn_reg, yn_reg, xn_next, yn_next;

    // stage enables, a stage moves when empty or when the next one moves
    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // offset from the principal point in sixteenths of a pixel
    assign dx_next = $signed({2'b00, pixel_col, 4'b0000}) - $signed({2'b00, cfg.center_x});
    assign dy_next = $signed({2'b00, pixel_row, 4'b0000}) - $signed({2'b00, cfg.center_y});

    // scale by 1/f, Q.4 times Q0.24 down to Q.20
    assign px_prod = dx_reg * $signed({1'b0, cfg.inv_focal_x});
    assign py_prod = dy_reg * $signed({1'b0, cfg.inv_focal_y});
    assign px_rnd  = (px_prod + HALF_LSB) >>> SCALE_SH;
    assign py_rnd  = (py_prod + HALF_LSB) >>> SCALE_SH;
    assign xn_next = clamp_norm(px_rnd);
    assign yn_next = clamp_norm(py_rnd);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            d1_reg <= depth_mm;
        end
        if (en2 && v1_reg)
        begin
            xn_reg <= xn_next;
            yn_reg <= yn_next;
            d2_reg <= d1_reg;
        end
    end

    assign out_valid      = v2_reg;
    assign out_data.xn    = xn_reg;
    assign out_data.yn    = yn_reg;
    assign out_data.depth = d2_reg;

endmodule

/* hdl/dpd_distort.sv */
// ----------------------------------------------------------------------------
// dpd_distort: inverse Brown-Conrady correction
// Six stages: squares, r^4, r^6 and coefficient products, radial factor and
// tangential sums, split products of the factor, final sum and rounding.
// ----------------------------------------------------------------------------
module dpd_distort import dpd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  norm_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output ray_t  out_data
);

    localparam int NST   = 6;
    localparam int SQP_W = 2 * NORM_W;
    localparam int SQ_W  = 25;
    localparam int XY_W  = 26;
    localparam int R2_W  = SQ_W + 1;
    localparam int R4_W  = 31;
    localparam int R6_W  = 36;
    localparam int T_W   = R2_W + 1;
    localparam int PK1_W = COEF_W + R2_W + 1;
    localparam int PK2_W = COEF_W + R4_W + 1;
    localparam int POLY_W = COEF_W + R6_W + 1;
    localparam int TA_W  = COEF_W + XY_W;
    localparam int TB_W  = COEF_W + T_W + 1;
    localparam int FLO_W = FRAC;
    localparam int FHI_W = FACTOR_W - FRAC;
    localparam int MHI_W = NORM_W + FHI_W;
    localparam int MLO_W = NORM_W + FLO_W + 1;
    localparam int ACC_W = 64;

    localparam logic signed [SQP_W-1:0]     HALF_SQ   = SQP_W'(1) <<< (FRAC - 1);
    localparam logic [2*R2_W-1:0]           HALF_R4   = (2*R2_W)'(1) << (FRAC - 1);
    localparam logic [R4_W+R2_W-1:0]        HALF_R6   = (R4_W+R2_W)'(1) << (FRAC - 1);
    localparam logic signed [POLY_W-1:0]    HALF_POLY = POLY_W'(1) <<< (FRAC - 1);
    localparam logic signed [FACTOR_W-1:0]  ONE_Q20   = FACTOR_W'(1) <<< FRAC;
    localparam logic signed [ACC_W-1:0]     HALF_ACC  = ACC_W'(1) <<< (FRAC - 1);

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    // stage 3: squares and cross term
    logic signed [SQP_W-1:0]   sq_xx, sq_yy, sq_xy;
    logic signed [SQP_W-1:0]   rnd_xx, rnd_yy, rnd_xy;
    logic        [SQ_W-1:0]    xx3_reg, yy3_reg;
    logic signed [XY_W-1:0]    xy3_reg;
    logic signed [NORM_W-1:0]  xn3_reg, yn3_reg;
    logic        [DEPTH_W-1:0] d3_reg;

    // stage 4: r^2 and r^4
    logic        [R2_W-1:0]    r2_next;
    logic        [2*R2_W-1:0]  r2_sq;
    logic        [R2_W-1:0]    r2_4_reg;
    logic        [R4_W-1:0]    r4_4_reg;
    logic        [SQ_W-1:0]    xx4_reg, yy4_reg;
    logic signed [XY_W-1:0]    xy4_reg;
    logic signed [NORM_W-1:0]  xn4_reg, yn4_reg;
    logic        [DEPTH_W-1:0] d4_reg;

    // stage 5: r^6 and coefficient products
    logic        [R4_W+R2_W-1:0] r6_prod;
    logic        [T_W-1:0]       tsum_x, tsum_y;
    logic        [R6_W-1:0]      r6_5_reg;
    logic signed [PK1_W-1:0]     pk1_5_reg;
    logic signed [PK2_W-1:0]     pk2_5_reg;
    logic signed [TA_W-1:0]      tax_5_reg, tay_5_reg;
    logic signed [TB_W-1:0]      tbx_5_reg, tby_5_reg;
    logic signed [NORM_W-1:0]    xn5_reg, yn5_reg;
    logic        [DEPTH_W-1:0]   d5_reg;

    // stage 6: radial factor and tangential sums
    logic signed [POLY_W-1:0]   pk3, poly;
    logic signed [FACTOR_W-1:0] f_next, f6_reg;
    logic signed [TAN_W-1:0]    tx_next, ty_next, tx6_reg, ty6_reg;
    logic signed [NORM_W-1:0]   xn6_reg, yn6_reg;
    logic        [DEPTH_W-1:0]  d6_reg;

    // stage 7: factor times coordinate, split in two halves
    logic signed [FHI_W-1:0]    f_hi;
    logic        [FLO_W-1:0]    f_lo;
    logic signed [MHI_W-1:0]    mxh_7_reg, myh_7_reg;
    logic signed [MLO_W-1:0]    mxl_7_reg, myl_7_reg;
    logic signed [TAN_W-1:0]    tx7_reg, ty7_reg;
    logic        [DEPTH_W-1:0]  d7_reg;

    // stage 8: final sum
    logic signed [ACC_W-1:0]    acc_x, acc_y;
    logic signed [UNIT_W-1:0]   ux8_reg, uy8_reg;
    logic        [DEPTH_W-1:0]  d8_reg;

    // stage enables from the output back
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
    end
    assign in_ready = en[0];

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // stage 3 math
    assign sq_xx  = in_data.xn * in_data.xn;
    assign sq_yy  = in_data.yn * in_data.yn;
    assign sq_xy  = in_data.xn * in_data.yn;
    assign rnd_xx = sq_xx + HALF_SQ;
    assign rnd_yy = sq_yy + HALF_SQ;
    assign rnd_xy = sq_xy + HALF_SQ;

    // stage 4 math
    assign r2_next = R2_W'(xx3_reg) + R2_W'(yy3_reg);
    assign r2_sq   = r2_next * r2_next + HALF_R4;

    // stage 5 math
    assign r6_prod = r4_4_reg * r2_4_reg + HALF_R6;
    assign tsum_x  = T_W'(r2_4_reg) + T_W'({xx4_reg, 1'b0});
    assign tsum_y  = T_W'(r2_4_reg) + T_W'({yy4_reg, 1'b0});

    // stage 6 math
    assign pk3     = DIST_K3 * $signed({1'b0, r6_5_reg});
    assign poly    = POLY_W'(pk1_5_reg) + POLY_W'(pk2_5_reg) + pk3 + HALF_POLY;
    assign f_next  = FACTOR_W'(poly >>> FRAC) + ONE_Q20;
    assign tx_next = (TAN_W'(tax_5_reg) <<< 1) + TAN_W'(tbx_5_reg);
    assign ty_next = (TAN_W'(tay_5_reg) <<< 1) + TAN_W'(tby_5_reg);

    // stage 7 math
    assign f_hi = $signed(f6_reg[FACTOR_W-1:FRAC]);
    assign f_lo = f6_reg[FRAC-1:0];

    // stage 8 math
    assign acc_x = (ACC_W'(mxh_7_reg) <<< FRAC) + ACC_W'(mxl_7_reg) + ACC_W'(tx7_reg) + HALF_ACC;
    assign acc_y = (ACC_W'(myh_7_reg) <<< FRAC) + ACC_W'(myl_7_reg) + ACC_W'(ty7_reg) + HALF_ACC;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid)
        begin
            xx3_reg <= rnd_xx[FRAC+SQ_W-1:FRAC];
            yy3_reg <= rnd_yy[FRAC+SQ_W-1:FRAC];
            xy3_reg <= $signed(rnd_xy[FRAC+XY_W-1:FRAC]);
            xn3_reg <= in_data.xn;
            yn3_reg <= in_data.yn;
            d3_reg  <= in_data.depth;
        end
        if (en[1] && v_reg[0])
        begin
            r2_4_reg <= r2_next;
            r4_4_reg <= r2_sq[FRAC+R4_W-1:FRAC];
            xx4_reg  <= xx3_reg;
            yy4_reg  <= yy3_reg;
            xy4_reg  <= xy3_reg;
            xn4_reg  <= xn3_reg;
            yn4_reg  <= yn3_reg;
            d4_reg   <= d3_reg;
        end
        if (en[2] && v_reg[1])
        begin
            r6_5_reg  <= r6_prod[FRAC+R6_W-1:FRAC];
            pk1_5_reg <= cfg.radial_k1 * $signed({1'b0, r2_4_reg});
            pk2_5_reg <= cfg.radial_k2 * $signed({1'b0, r4_4_reg});
            tax_5_reg <= cfg.tangential_p1 * xy4_reg;
            tay_5_reg <= cfg.tangential_p2 * xy4_reg;
            tbx_5_reg <= cfg.tangential_p2 * $signed({1'b0, tsum_x});
            tby_5_reg <= cfg.tangential_p1 * $signed({1'b0, tsum_y});
            xn5_reg   <= xn4_reg;
            yn5_reg   <= yn4_reg;
            d5_reg    <= d4_reg;
        end
        if (en[3] && v_reg[2])
        begin
            f6_reg  <= f_next;
            tx6_reg <= tx_next;
            ty6_reg <= ty_next;
            xn6_reg <= xn5_reg;
            yn6_reg <= yn5_reg;
            d6_reg  <= d5_reg;
        end
        if (en[4] && v_reg[3])
        begin
            mxh_7_reg <= xn6_reg * f_hi;
            myh_7_reg <= yn6_reg * f_hi;
            mxl_7_reg <= xn6_reg * $signed({1'b0, f_lo});
            myl_7_reg <= yn6_reg * $signed({1'b0, f_lo});
            tx7_reg   <= tx6_reg;
            ty7_reg   <= ty6_reg;
            d7_reg    <= d6_reg;
        end
        if (en[5] && v_reg[4])
        begin
            ux8_reg <= UNIT_W'(acc_x >>> FRAC);
            uy8_reg <= UNIT_W'(acc_y >>> FRAC);
            d8_reg  <= d7_reg;
        end
    end

    assign out_valid      = v_reg[NST-1];
    assign out_data.ux    = ux8_reg;
    assign out_data.uy    = uy8_reg;
    assign out_data.depth = d8_reg;

endmodule

/* hdl/dpd_scale.sv */
// ----------------------------------------------------------------------------
// dpd_scale: depth scaling and output clamp
// Two stages: split depth products, then sum, round and saturate to the
// 19 bit millimetre range. The last stage is the output register.
// ----------------------------------------------------------------------------
module dpd_scale import dpd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  ray_t                      in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] point_x,
    output logic signed [COORD_W-1:0] point_y,
    output logic        [DEPTH_W-1:0] point_z,
    output logic                      saturated
);

    localparam int SPLIT  = 21;
    localparam int UHI_W  = UNIT_W - SPLIT;
    localparam int DEP_W  = DEPTH_W + 1;
    localparam int PP_W   = DEP_W + UHI_W;
    localparam int ACC_W  = 60;
    localparam int PT_W   = ACC_W - FRAC;
    localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(1) <<< (FRAC - 1);
    localparam logic signed [PT_W-1:0]  OUT_HI   = (PT_W'(1) <<< (COORD_W - 1)) - 1;
    localparam logic signed [PT_W-1:0]  OUT_LO   = -(PT_W'(1) <<< (COORD_W - 1));

    logic                      v9_reg, v10_reg;
    logic                      en9, en10;
    logic signed [DEP_W-1:0]   dep;
    logic signed [PP_W-1:0]    axh_reg, ayh_reg, axl_reg, ayl_reg;
    logic        [DEPTH_W-1:0] d9_reg;
    logic signed [ACC_W-1:0]   acc_x, acc_y;
    logic signed [PT_W-1:0]    px, py;
    logic signed [COORD_W-1:0] x_next, y_next;
    logic                      sat_next;
    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic        [DEPTH_W-1:0] z_reg;
    logic                      sat_reg;

    assign en10     = !v10_reg || out_ready;
    assign en9      = !v9_reg || en10;
    assign in_ready = en9;

    // depth times ray, each coordinate split at bit SPLIT
    assign dep = $signed({1'b0, in_data.depth});

    // recombine and round to whole millimetres
    assign acc_x = (ACC_W'(axh_reg) <<< SPLIT) + ACC_W'(axl_reg) + HALF_ACC;
    assign acc_y = (ACC_W'(ayh_reg) <<< SPLIT) + ACC_W'(ayl_reg) + HALF_ACC;
    assign px    = PT_W'(acc_x >>> FRAC);
    assign py    = PT_W'(acc_y >>> FRAC);

    // clamp to the output range and flag it
    always_comb
    begin
        sat_next = 1'b0;
        if (px > OUT_HI)
        begin
            x_next   = OUT_HI[COORD_W-1:0];
            sat_next = 1'b1;
        end
        else if (px < OUT_LO)
        begin
            x_next   = OUT_LO[COORD_W-1:0];
            sat_next = 1'b1;
        end
        else
        begin
            x_next = px[COORD_W-1:0];
        end
        if (py > OUT_HI)
        begin
            y_next   = OUT_HI[COORD_W-1:0];
            sat_next = 1'b1;
        end
        else if (py < OUT_LO)
        begin
            y_next   = OUT_LO[COORD_W-1:0];
            sat_next = 1'b1;
        end
        else
        begin
            y_next = py[COORD_W-1:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else
        begin
            if (en9)
                v9_reg <= in_valid;
            if (en10)
                v10_reg <= v9_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en9 && in_valid)
        begin
            axh_reg <= dep * $signed(in_data.ux[UNIT_W-1:SPLIT]);
            ayh_reg <= dep * $signed(in_data.uy[UNIT_W-1:SPLIT]);
            axl_reg <= dep * $signed({1'b0, in_data.ux[SPLIT-1:0]});
            ayl_reg <= dep * $signed({1'b0, in_data.uy[SPLIT-1:0]});
            d9_reg  <= in_data.depth;
        end
        if (en10 && v9_reg)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= d9_reg;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = v10_reg;
    assign point_x   = x_reg;
    assign point_y   = y_reg;
    assign point_z   = z_reg;
    assign saturated = sat_reg;

    // no depth gives the origin and no clip
    a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && point_z == '0) |-> (point_x == '0 && point_y == '0 && !saturated))
        else $error("zero depth produced a nonzero point");

    // a clip flag means a coordinate sits on a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
        (point_x == OUT_HI[COORD_W-1:0] || point_x == OUT_LO[COORD_W-1:0] ||
         point_y == OUT_HI[COORD_W-1:0] || point_y == OUT_LO[COORD_W-1:0]))
        else $error("saturated set without a clipped coordinate");

endmodule

/* hdl/depth_pixel_deproject_top.sv */
// Ten register stages lie between an accepted pixel beat and its point beat.
// Throughput: one pixel per cycle while the point output is not stalled; every stage takes one beat a cycle.
// A stalled output holds only the stages behind it, empty stages keep filling.
// Reset clears every stage valid bit and loads the default camera model registers.
// ----------------------------------------------------------------------------
// depth_pixel_deproject_top: pinhole deprojection with lens correction
// Pixel plus depth in, camera-frame point in millimetres out, with an APB-style
// register port for intrinsics and distortion coefficients.
// ----------------------------------------------------------------------------
module depth_pixel_deproject_top import dpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    dpd_pixel_if.sink         pixel_ch,
    dpd_point_if.source       point_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t  cfg;
    logic  norm_valid, norm_ready;
    norm_t norm_data;
    logic  ray_valid, ray_ready;
    ray_t  ray_data;

    // camera model registers
    dpd_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // normalisation front end
    dpd_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (pixel_ch.valid),
        .in_ready  (pixel_ch.ready),
        .pixel_col (pixel_ch.pixel_col),
        .pixel_row (pixel_ch.pixel_row),
        .depth_mm  (pixel_ch.depth_mm),
        .out_valid (norm_valid),
        .out_ready (norm_ready),
        .out_data  (norm_data)
    );

    // distortion correction
    dpd_distort u_distort
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (norm_valid),
        .in_ready  (norm_ready),
        .in_data   (norm_data),
        .out_valid (ray_valid),
        .out_ready (ray_ready),
        .out_data  (ray_data)
    );

    // depth scaling and output register
    dpd_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ray_valid),
        .in_ready  (ray_ready),
        .in_data   (ray_data),
        .out_valid (point_ch.valid),
        .out_ready (point_ch.ready),
        .point_x   (point_ch.point_x),
        .point_y   (point_ch.point_y),
        .point_z   (point_ch.point_z),
        .saturated (point_ch.saturated)
    );

    // input back-pressure only when the whole pipe is full behind a stalled output
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ch.ready |-> (point_ch.valid && !point_ch.ready && ray_valid && norm_valid))
        else $error("input stalled while the pipeline has room");

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for depth_pixel_deproject_top
// Pixel beats are queued by a stimulus thread and driven with random gaps.
// Each accepted pixel is projected by a local fixed point model into the
// camera-frame point it should produce. Point beats taken under random
// backpressure are compared field by field, in order, against that model.
// The camera registers are rewritten over the APB port between drained phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dpd_pkg::*;

    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     LONG_HOLD      = 200;
    localparam int     TAIL_CYCLES    = 20;
    localparam int     MAX_REPORTS    = 100;
    localparam longint NORM_HI        = (longint'(1) << (NORM_W - 1)) - 1;
    localparam longint NORM_LO        = -(longint'(1) << (NORM_W - 1));
    localparam longint OUT_HI         = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint OUT_LO         = -(longint'(1) << (COORD_W - 1));
    localparam int     RESET_INV_FOCAL = 27962;
    localparam int     RESET_CENTER_X  = 5120;
    localparam int     RESET_CENTER_Y  = 3840;

    typedef struct {
        logic [PIX_W-1:0]   col;
        logic [PIX_W-1:0]   row;
        logic [DEPTH_W-1:0] depth;
    } pixel_beat_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [DEPTH_W-1:0] z;
        logic                      sat;
        pixel_beat_t               src;
    } point_beat_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    dpd_pixel_if pixel_ch ();
    dpd_point_if point_ch ();

    depth_pixel_deproject_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel_ch (pixel_ch),
        .point_ch (point_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pixel_beat_t pixel_queue[$];
    point_beat_t pending_points[$];
    cfg_t        camera;
    int          error_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_req;
    int          hold_ack;
    int          hold_left;
    int          quiet_cycles;
    pixel_beat_t next_pixel;
    pixel_beat_t seen_pixel;
    point_beat_t want;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // round half up after an arithmetic right shift
    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi, inout bit hit);
        if (v > hi)
        begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // pinhole back projection with inverse lens correction, scaled by depth
    function automatic point_beat_t deproject_pixel(pixel_beat_t p, cfg_t c);
        longint      dx, dy, xn, yn, xx, yy, xy, r2, r4, r6;
        longint      gain, ux, uy, depth, px, py;
        bit          norm_hit;
        bit          clipped;
        point_beat_t r;
        norm_hit = 1'b0;
        clipped  = 1'b0;
        depth = longint'(p.depth);
        dx = longint'(p.col) * 16 - longint'(c.center_x);
        dy = longint'(p.row) * 16 - longint'(c.center_y);
        // normalised coordinates, clamped silently
        xn = clip(round_shift(dx * longint'(c.inv_focal_x), 8), NORM_LO, NORM_HI, norm_hit);
        yn = clip(round_shift(dy * longint'(c.inv_focal_y), 8), NORM_LO, NORM_HI, norm_hit);
        xx = round_shift(xn * xn, FRAC);
        yy = round_shift(yn * yn, FRAC);
        xy = round_shift(xn * yn, FRAC);
        r2 = xx + yy;
        r4 = round_shift(r2 * r2, FRAC);
        r6 = round_shift(r4 * r2, FRAC);
        // radial gain then tangential terms
        gain = (longint'(1) << FRAC)
             + round_shift(longint'(c.radial_k1) * r2 + longint'(c.radial_k2) * r4
                           + longint'(DIST_K3) * r6, FRAC);
        ux = round_shift(xn * gain + 2 * longint'(c.tangential_p1) * xy
                         + longint'(c.tangential_p2) * (r2 + 2 * xx), FRAC);
        uy = round_shift(yn * gain + 2 * longint'(c.tangential_p2) * xy
                         + longint'(c.tangential_p1) * (r2 + 2 * yy), FRAC);
        // scale by depth, saturate to the output range
        px = clip(round_shift(depth * ux, FRAC), OUT_LO, OUT_HI, clipped);
        py = clip(round_shift(depth * uy, FRAC), OUT_LO, OUT_HI, clipped);
        r.x   = px[COORD_W-1:0];
        r.y   = py[COORD_W-1:0];
        r.z   = p.depth;
        r.sat = clipped;
        r.src = p;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (error_count < MAX_REPORTS)
            $display("mismatch at %0t ns: %s", $realtime, msg);
        error_count++;
    endtask

    // apb write: setup then access, register loads on the access edge
    task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_camera(cfg_t c);
        apb_write(REG_INV_FOCAL_X, DATA_W'(c.inv_focal_x));
        apb_write(REG_INV_FOCAL_Y, DATA_W'(c.inv_focal_y));
        apb_write(REG_CENTER_X,    DATA_W'(c.center_x));
        apb_write(REG_CENTER_Y,    DATA_W'(c.center_y));
        apb_write(REG_RADIAL_K1,   {8'd0, c.radial_k1});
        apb_write(REG_RADIAL_K2,   {8'd0, c.radial_k2});
        apb_write(REG_TANGENT_P1,  {8'd0, c.tangential_p1});
        apb_write(REG_TANGENT_P2,  {8'd0, c.tangential_p2});
        camera = c;
    endtask

    task automatic push_pixel(int col, int row, int depth);
        pixel_beat_t p;
        p.col   = PIX_W'(col);
        p.row   = PIX_W'(row);
        p.depth = DEPTH_W'(depth);
        pixel_queue.push_back(p);
    endtask

    function automatic logic [COEF_W-1:0] small_coef(int span);
        return COEF_W'($urandom_range(0, 2 * span) - span);
    endfunction

    // mostly pixels inside a typical frame, the rest anywhere
    task automatic push_random_pixel();
        int col, row, depth;
        if ($urandom_range(99) < 60)
        begin
            col = $urandom_range(0, 1279);
            row = $urandom_range(0, 959);
        end
        else
        begin
            col = $urandom_range(0, (1 << PIX_W) - 1);
            row = $urandom_range(0, (1 << PIX_W) - 1);
        end
        case ($urandom_range(9))
            0:       depth = 0;
            1:       depth = (1 << DEPTH_W) - 1;
            2:       depth = $urandom_range(1, 255);
            default: depth = $urandom_range(0, (1 << DEPTH_W) - 1);
        endcase
        push_pixel(col, row, depth);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pixel_queue.size() != 0 || pixel_ch.valid || pending_points.size() != 0)
            @(negedge clk);
    endtask

    // queue random pixels under one idling mode, then drain
    task automatic run_phase(int send_pct, int stall_pct, int count, bit long_hold);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            push_random_pixel();
        if (long_hold)
            hold_req++;
        wait_drained();
    endtask

    // pixel driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pixel_ch.valid     <= 1'b0;
            pixel_ch.pixel_col <= '0;
            pixel_ch.pixel_row <= '0;
            pixel_ch.depth_mm  <= '0;
        end
        else if (!pixel_ch.valid || pixel_ch.ready)
        begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_pixel = pixel_queue.pop_front();
                pixel_ch.valid     <= 1'b1;
                pixel_ch.pixel_col <= next_pixel.col;
                pixel_ch.pixel_row <= next_pixel.row;
                pixel_ch.depth_mm  <= next_pixel.depth;
            end
            else
                pixel_ch.valid <= 1'b0;
        end
    end

    // point ready, with random stalls and requested long hold-offs
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            point_ch.ready <= 1'b0;
            hold_ack       <= 0;
            hold_left      <= 0;
        end
        else if (hold_left > 0)
        begin
            point_ch.ready <= 1'b0;
            hold_left      <= hold_left - 1;
        end
        else if (hold_ack != hold_req)
        begin
            point_ch.ready <= 1'b0;
            hold_ack       <= hold_req;
            hold_left      <= LONG_HOLD;
        end
        else
            point_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // predict on accepted pixel beats, check accepted point beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                seen_pixel.col   = pixel_ch.pixel_col;
                seen_pixel.row   = pixel_ch.pixel_row;
                seen_pixel.depth = pixel_ch.depth_mm;
                pending_points.push_back(deproject_pixel(seen_pixel, camera));
            end
            if (point_ch.valid && point_ch.ready)
            begin
                if (pending_points.size() == 0)
                    report_mismatch("point beat with no pixel outstanding");
                else
                begin
                    want = pending_points.pop_front();
                    if (point_ch.point_x !== want.x)
                        report_mismatch($sformatf("point_x %0d, want %0d (pixel %0d,%0d depth %0d)",
                            point_ch.point_x, want.x, want.src.col, want.src.row, want.src.depth));
                    if (point_ch.point_y !== want.y)
                        report_mismatch($sformatf("point_y %0d, want %0d (pixel %0d,%0d depth %0d)",
                            point_ch.point_y, want.y, want.src.col, want.src.row, want.src.depth));
                    if (point_ch.point_z !== want.z)
                        report_mismatch($sformatf("point_z %0d, want %0d (pixel %0d,%0d)",
                            point_ch.point_z, want.z, want.src.col, want.src.row));
                    if (point_ch.saturated !== want.sat)
                        report_mismatch($sformatf("saturated %b, want %b (pixel %0d,%0d depth %0d)",
                            point_ch.saturated, want.sat, want.src.col, want.src.row,
                            want.src.depth));
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (pixel_ch.valid && pixel_ch.ready) || (point_ch.valid && point_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus
    initial
    begin
        cfg_t cam;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        error_count        = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_req           = 0;
        camera.inv_focal_x   = FOCAL_W'(RESET_INV_FOCAL);
        camera.inv_focal_y   = FOCAL_W'(RESET_INV_FOCAL);
        camera.center_x      = CENTER_W'(RESET_CENTER_X);
        camera.center_y      = CENTER_W'(RESET_CENTER_Y);
        camera.radial_k1     = '0;
        camera.radial_k2     = '0;
        camera.tangential_p1 = '0;
        camera.tangential_p2 = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset camera: zero depth, corners, principal point, far coordinates
        push_pixel(0, 0, 0);
        push_pixel(4095, 4095, 0);
        push_pixel(0, 0, 65535);
        push_pixel(4095, 4095, 65535);
        push_pixel(4095, 0, 1);
        push_pixel(0, 4095, 1);
        push_pixel(320, 240, 1000);
        push_pixel(321, 241, 65535);
        push_pixel(1279, 959, 12345);
        push_pixel(2048, 2048, 65535);
        run_phase(0, 0, 150, 1'b1);

        // extreme camera: widest field, strong distortion, output overflow
        cam.inv_focal_x   = '1;
        cam.inv_focal_y   = '1;
        cam.center_x      = '0;
        cam.center_y      = '1;
        cam.radial_k1     = {1'b0, {(COEF_W-1){1'b1}}};
        cam.radial_k2     = {1'b1, {(COEF_W-1){1'b0}}};
        cam.tangential_p1 = {1'b0, {(COEF_W-1){1'b1}}};
        cam.tangential_p2 = {1'b1, {(COEF_W-1){1'b0}}};
        load_camera(cam);
        push_pixel(0, 0, 65535);
        push_pixel(4095, 4095, 65535);
        push_pixel(4095, 0, 65535);
        push_pixel(0, 4095, 0);
        push_pixel(1, 1, 1);
        push_pixel(4095, 4095, 1);
        run_phase(48, 0, 100, 1'b0);

        // zero reciprocal focal lengths, far principal point
        cam.inv_focal_x   = '0;
        cam.inv_focal_y   = '0;
        cam.center_x      = '1;
        cam.center_y      = '1;
        cam.radial_k1     = {1'b1, {(COEF_W-1){1'b0}}};
        cam.radial_k2     = {1'b0, {(COEF_W-1){1'b1}}};
        cam.tangential_p1 = {1'b1, {(COEF_W-1){1'b0}}};
        cam.tangential_p2 = {1'b0, {(COEF_W-1){1'b1}}};
        load_camera(cam);
        push_pixel(0, 0, 65535);
        push_pixel(4095, 4095, 65535);
        push_pixel(4095, 4095, 0);
        run_phase(0, 48, 100, 1'b0);

        // typical lens
        cam.inv_focal_x   = FOCAL_W'((1 << 24) / $urandom_range(300, 1500));
        cam.inv_focal_y   = FOCAL_W'((1 << 24) / $urandom_range(300, 1500));
        cam.center_x      = CENTER_W'($urandom_range(0, 1280 * 16));
        cam.center_y      = CENTER_W'($urandom_range(0, 960 * 16));
        cam.radial_k1     = small_coef(1 << 19);
        cam.radial_k2     = small_coef(1 << 19);
        cam.tangential_p1 = small_coef(10000);
        cam.tangential_p2 = small_coef(10000);
        load_camera(cam);
        run_phase(15, 15, 200, 1'b0);

        // any register pattern
        cam.inv_focal_x   = FOCAL_W'($urandom());
        cam.inv_focal_y   = FOCAL_W'($urandom());
        cam.center_x      = CENTER_W'($urandom());
        cam.center_y      = CENTER_W'($urandom());
        cam.radial_k1     = COEF_W'($urandom());
        cam.radial_k2     = COEF_W'($urandom());
        cam.tangential_p1 = COEF_W'($urandom());
        cam.tangential_p2 = COEF_W'($urandom());
        load_camera(cam);
        run_phase(0, 48, 150, 1'b0);

        // opposite coefficient extremes with a random focal length
        cam.inv_focal_x   = FOCAL_W'($urandom());
        cam.inv_focal_y   = FOCAL_W'($urandom());
        cam.center_x      = CENTER_W'($urandom());
        cam.center_y      = CENTER_W'($urandom());
        cam.radial_k1     = {1'b1, {(COEF_W-1){1'b0}}};
        cam.radial_k2     = {1'b1, {(COEF_W-1){1'b0}}};
        cam.tangential_p1 = {1'b0, {(COEF_W-1){1'b1}}};
        cam.tangential_p2 = {1'b0, {(COEF_W-1){1'b1}}};
        load_camera(cam);
        run_phase(48, 0, 100, 1'b0);

        // typical lens again, second long hold-off on the point side
        cam.inv_focal_x   = FOCAL_W'((1 << 24) / $urandom_range(300, 1500));
        cam.inv_focal_y   = FOCAL_W'((1 << 24) / $urandom_range(300, 1500));
        cam.center_x      = CENTER_W'($urandom_range(0, 1280 * 16));
        cam.center_y      = CENTER_W'($urandom_range(0, 960 * 16));
        cam.radial_k1     = small_coef(1 << 19);
        cam.radial_k2     = small_coef(1 << 19);
        cam.tangential_p1 = small_coef(10000);
        cam.tangential_p2 = small_coef(10000);
        load_camera(cam);
        run_phase(0, 0, 200, 1'b1);

        // any register pattern, both sides idling
        cam.inv_focal_x   = FOCAL_W'($urandom());
        cam.inv_focal_y   = FOCAL_W'($urandom());
        cam.center_x      = CENTER_W'($urandom());
        cam.center_y      = CENTER_W'($urandom());
        cam.radial_k1     = COEF_W'($urandom());
        cam.radial_k2     = COEF_W'($urandom());
        cam.tangential_p1 = COEF_W'($urandom());
        cam.tangential_p2 = COEF_W'($urandom());
        load_camera(cam);
        run_phase(15, 15, 100, 1'b0);

        // let any stray beat show up, then the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_points.size() != 0)
            report_mismatch($sformatf("%0d points never arrived", pending_points.size()));
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
hdl/dpd_pkg.sv
hdl/dpd_pixel_if.sv
hdl/dpd_point_if.sv
hdl/dpd_cfg_regs.sv
hdl/dpd_norm.sv
hdl/dpd_distort.sv
hdl/dpd_scale.sv
hdl/depth_pixel_deproject_top.sv
test/tb.sv
